### rtl/sfs_pkg.sv
package sfs_pkg;

   localparam int COUNT_WIDTH = 8;
   localparam int TIMER_WIDTH = 24;

   localparam int SF_COUNT    = 6;
   localparam int SF_WIDTH    = 4;
   localparam int INDEX_WIDTH = 3;
   localparam int RSSI_WIDTH  = 9;
   localparam int SNR_WIDTH   = 8;
   localparam int DWELL_WIDTH = 24;
   localparam int CSR_DATA_WIDTH  = DWELL_WIDTH;
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int LIMIT_WIDTH = (TIMER_WIDTH > DWELL_WIDTH) ? TIMER_WIDTH : DWELL_WIDTH;

   localparam logic [SF_WIDTH-1:0]    SF_LOW  = 4'd7;
   localparam logic [SF_WIDTH-1:0]    SF_HIGH = 4'd12;
   localparam logic [INDEX_WIDTH-1:0] LAST_INDEX = 3'(SF_COUNT - 1);

   localparam logic signed [RSSI_WIDTH-1:0] RSSI_FLOOR = -9'sd140;
   localparam logic signed [SNR_WIDTH-1:0]  SNR_FLOOR  = -8'sd20;

   localparam logic [DWELL_WIDTH-1:0] DWELL_RESET      = 24'd5000;
   localparam logic [SF_WIDTH-1:0]    DEFAULT_SF_RESET = SF_LOW;

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
   localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = '1;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_DWELL_TICKS = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_DEFAULT_SF  = 1'd1;

   typedef enum logic [1:0] {
      ACT_START  = 2'd0,
      ACT_PACKET = 2'd1,
      ACT_TICK   = 2'd2
   } action_type;

   typedef logic [COUNT_WIDTH-1:0]            count_type;
   typedef logic signed [RSSI_WIDTH-1:0]      rssi_type;
   typedef logic signed [SNR_WIDTH-1:0]       snr_type;

   typedef count_type count_array_type [SF_COUNT];
   typedef rssi_type  rssi_array_type  [SF_COUNT];
   typedef snr_type   snr_array_type   [SF_COUNT];

   typedef struct packed {
      logic [SF_WIDTH-1:0] sf;
      rssi_type            rssi;
      snr_type             snr;
   } packet_type;

   // one decoded beat, only set on the cycle it is processed
   typedef struct packed {
      logic start;
      logic packet;
      logic tick;
   } scan_cmd_type;

   typedef struct packed {
      logic                   scanning;
      logic                   scanning_next;
      logic                   dwell_end;
      logic                   last_factor;
      logic [INDEX_WIDTH-1:0] factor_index;
      logic [SF_WIDTH-1:0]    next_sf;
   } scan_status_type;

endpackage

### rtl/sfs_req_if.sv
interface sfs_req_if;
   import sfs_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [1:0]             action;
   logic [SF_WIDTH-1:0]    packet_sf;
   logic signed [RSSI_WIDTH-1:0] packet_rssi;
   logic signed [SNR_WIDTH-1:0]  packet_snr;

   modport source (output valid, action, packet_sf, packet_rssi, packet_snr, input ready);
   modport sink   (input valid, action, packet_sf, packet_rssi, packet_snr, output ready);
endinterface

### rtl/sfs_rsp_if.sv
interface sfs_rsp_if;
   import sfs_pkg::*;

   logic                   valid;
   logic                   ready;
   logic                   tune_valid;
   logic [SF_WIDTH-1:0]    tune_sf;
   logic                   scan_busy;
   logic                   scan_done;
   logic [SF_WIDTH-1:0]    best_sf;
   logic [SF_COUNT-1:0]    activity_mask;

   modport source (output valid, tune_valid, tune_sf, scan_busy, scan_done, best_sf,
                   activity_mask, input ready);
   modport sink   (input valid, tune_valid, tune_sf, scan_busy, scan_done, best_sf,
                   activity_mask, output ready);
endinterface

### rtl/sfs_scan_ctrl.sv
module sfs_scan_ctrl (
   input  logic                             clock,
   input  logic                             reset,
   input  sfs_pkg::scan_cmd_type            cmd,
   input  logic [sfs_pkg::DWELL_WIDTH-1:0]  dwell_ticks,
   output sfs_pkg::scan_status_type         status
);
   import sfs_pkg::*;

   logic                   scanning_ff, scanning_in;
   logic [INDEX_WIDTH-1:0] index_ff, index_in;
   logic [TIMER_WIDTH-1:0] elapsed_ff, elapsed_in;

   logic [TIMER_WIDTH-1:0] elapsed_inc;
   logic [LIMIT_WIDTH-1:0] dwell_wide, tmax_wide, limit;
   logic [INDEX_WIDTH-1:0] factor;
   logic                   dwell_end, last_factor;

   always_comb begin
      elapsed_inc = (elapsed_ff == TIMER_MAX) ? elapsed_ff : elapsed_ff + 1'b1;
      dwell_wide  = LIMIT_WIDTH'(dwell_ticks);
      tmax_wide   = LIMIT_WIDTH'(TIMER_MAX);
      limit       = (dwell_wide > tmax_wide) ? tmax_wide : dwell_wide;
      factor      = (index_ff > LAST_INDEX) ? LAST_INDEX : index_ff;
      last_factor = (factor == LAST_INDEX);
      dwell_end   = cmd.tick && scanning_ff && (LIMIT_WIDTH'(elapsed_inc) >= limit);
   end

   always_comb begin
      scanning_in = scanning_ff;
      index_in    = index_ff;
      elapsed_in  = elapsed_ff;
      if (cmd.start) begin
         scanning_in = 1'b1;
         index_in    = '0;
         elapsed_in  = '0;
      end else if (cmd.tick && scanning_ff) begin
         if (dwell_end) begin
            elapsed_in = '0;
            if (last_factor) begin
               scanning_in = 1'b0;
               index_in    = '0;
            end else begin
               index_in = factor + 1'b1;
            end
         end else begin
            elapsed_in = elapsed_inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scanning_ff <= 1'b0;
         index_ff    <= '0;
         elapsed_ff  <= '0;
      end else begin
         scanning_ff <= scanning_in;
         index_ff    <= index_in;
         elapsed_ff  <= elapsed_in;
      end
   end

   always_comb begin
      status.scanning      = scanning_ff;
      status.scanning_next = scanning_in;
      status.dwell_end     = dwell_end;
      status.last_factor   = last_factor;
      status.factor_index  = factor;
      status.next_sf       = SF_LOW + SF_WIDTH'(factor) + 1'b1;
   end
endmodule

### rtl/sfs_records.sv
module sfs_records (
   input  logic                               clock,
   input  logic                               reset,
   input  sfs_pkg::scan_cmd_type              cmd,
   input  sfs_pkg::packet_type                packet,
   input  logic                               mark,
   input  logic [sfs_pkg::INDEX_WIDTH-1:0]    mark_index,
   output sfs_pkg::count_array_type           counts,
   output sfs_pkg::rssi_array_type            peaks,
   output logic [sfs_pkg::SF_COUNT-1:0]       active_next
);
   import sfs_pkg::*;

   count_array_type     count_ff, count_in;
   rssi_array_type      rssi_ff, rssi_in;
   snr_array_type       snr_ff, snr_in;
   logic [SF_COUNT-1:0] active_ff, active_in;

   logic                   sf_ok;
   logic [INDEX_WIDTH-1:0] pkt_index;

   always_comb begin
      sf_ok     = (packet.sf >= SF_LOW) && (packet.sf <= SF_HIGH);
      pkt_index = INDEX_WIDTH'(packet.sf - SF_LOW);
   end

   // each record only looks at its own entry
   always_comb begin
      count_in  = count_ff;
      rssi_in   = rssi_ff;
      snr_in    = snr_ff;
      active_in = active_ff;
      for (int i = 0; i < SF_COUNT; i++) begin
         if (cmd.start) begin
            count_in[i]  = '0;
            rssi_in[i]   = RSSI_FLOOR;
            snr_in[i]    = SNR_FLOOR;
            active_in[i] = 1'b0;
         end else begin
            if (cmd.packet && sf_ok && pkt_index == INDEX_WIDTH'(i)) begin
               if (count_ff[i] != COUNT_MAX) count_in[i] = count_ff[i] + 1'b1;
               if (packet.rssi > rssi_ff[i]) rssi_in[i] = packet.rssi;
               if (packet.snr > snr_ff[i]) snr_in[i] = packet.snr;
            end
            if (mark && mark_index == INDEX_WIDTH'(i) && count_ff[i] != '0) begin
               active_in[i] = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SF_COUNT; i++) begin
            count_ff[i] <= '0;
            rssi_ff[i]  <= RSSI_FLOOR;
            snr_ff[i]   <= SNR_FLOOR;
         end
         active_ff <= '0;
      end else begin
         count_ff  <= count_in;
         rssi_ff   <= rssi_in;
         snr_ff    <= snr_in;
         active_ff <= active_in;
      end
   end

   assign counts      = count_ff;
   assign peaks       = rssi_ff;
   assign active_next = active_in;
endmodule

### rtl/sfs_best_pick.sv
module sfs_best_pick (
   input  sfs_pkg::count_array_type          counts,
   input  sfs_pkg::rssi_array_type           peaks,
   input  logic [sfs_pkg::SF_WIDTH-1:0]      default_sf,
   output logic [sfs_pkg::SF_WIDTH-1:0]      best_sf
);
   import sfs_pkg::*;

   logic [SF_WIDTH-1:0] fallback;
   logic [SF_WIDTH-1:0] best;
   count_type           most;
   rssi_type            rssi;

   always_comb begin
      if (default_sf < SF_LOW) fallback = SF_LOW;
      else if (default_sf > SF_HIGH) fallback = SF_HIGH;
      else fallback = default_sf;

      best = fallback;
      most = '0;
      rssi = RSSI_FLOOR;
      // most packets wins, strictly higher peak rssi breaks a tie
      for (int i = 0; i < SF_COUNT; i++) begin
         if (counts[i] > most) begin
            most = counts[i];
            best = SF_LOW + SF_WIDTH'(i);
            rssi = peaks[i];
         end else if (counts[i] == most && most != '0 && peaks[i] > rssi) begin
            best = SF_LOW + SF_WIDTH'(i);
            rssi = peaks[i];
         end
      end
      best_sf = (most == '0) ? fallback : best;
   end
endmodule

### rtl/spreading_factor_scan_selector.sv
// a request beat passes the input register, then the response register, to rsp_ch
// one beat per cycle unless stalled; a new request is taken while a response waits
// the input register holds one beat, the response register one; ready drops only
// when both are full and the response side stalls
// synchronous active-high reset: scan idle, records cleared, dwell 5000, default sf 7
module spreading_factor_scan_selector (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_enable,
   input  logic [sfs_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [sfs_pkg::CSR_DATA_WIDTH-1:0]   csr_write_data,
   sfs_req_if.sink                              req_ch,
   sfs_rsp_if.source                            rsp_ch
);
   import sfs_pkg::*;

   // configuration registers
   logic [DWELL_WIDTH-1:0] dwell_ff;
   logic [SF_WIDTH-1:0]    default_sf_ff;

   // input register
   logic                in_valid_ff, in_valid_in;
   logic [1:0]          action_ff;
   packet_type          packet_ff;

   // response register
   logic                rsp_valid_ff, rsp_valid_in;
   logic                tune_valid_ff, tune_valid_in;
   logic [SF_WIDTH-1:0] tune_sf_ff, tune_sf_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [SF_WIDTH-1:0] best_ff, best_in;
   logic [SF_COUNT-1:0] mask_ff, mask_in;

   logic                out_open, fire, req_take;
   scan_cmd_type        cmd;
   scan_status_type     status;
   count_array_type     counts;
   rssi_array_type      peaks;
   logic [SF_COUNT-1:0] active_next;
   logic [SF_WIDTH-1:0] best_sf;

   // handshake: the input beat moves on when the response register is empty or being read
   assign out_open     = !rsp_valid_ff || rsp_ch.ready;
   assign fire         = in_valid_ff && out_open;
   assign req_ch.ready = !in_valid_ff || out_open;
   assign req_take     = req_ch.valid && req_ch.ready;

   always_comb begin
      if (req_take) in_valid_in = 1'b1;
      else if (fire) in_valid_in = 1'b0;
      else in_valid_in = in_valid_ff;

      if (fire) rsp_valid_in = 1'b1;
      else if (rsp_ch.ready) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   // decode the held beat; packets only count while scanning, code three does nothing
   always_comb begin
      cmd = '0;
      if (fire) begin
         case (action_type'(action_ff))
            ACT_START:  cmd.start  = 1'b1;
            ACT_PACKET: cmd.packet = status.scanning;
            ACT_TICK:   cmd.tick   = status.scanning;
            default:    cmd        = '0;
         endcase
      end
   end

   sfs_scan_ctrl u_scan_ctrl (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .dwell_ticks (dwell_ff),
      .status      (status)
   );

   sfs_records u_records (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .packet      (packet_ff),
      .mark        (status.dwell_end),
      .mark_index  (status.factor_index),
      .counts      (counts),
      .peaks       (peaks),
      .active_next (active_next)
   );

   // ticks never change counts or peaks, so the current counts are final here
   sfs_best_pick u_best_pick (
      .counts     (counts),
      .peaks      (peaks),
      .default_sf (default_sf_ff),
      .best_sf    (best_sf)
   );

   // response fields for the beat being processed
   always_comb begin
      tune_valid_in = cmd.start || status.dwell_end;
      done_in       = status.dwell_end && status.last_factor;
      if (cmd.start) tune_sf_in = SF_LOW;
      else if (done_in) tune_sf_in = best_sf;
      else if (status.dwell_end) tune_sf_in = status.next_sf;
      else tune_sf_in = '0;
      best_in = done_in ? best_sf : '0;
      busy_in = status.scanning_next;
      mask_in = active_next;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         dwell_ff      <= DWELL_RESET;
         default_sf_ff <= DEFAULT_SF_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            case (csr_index)
               REG_DWELL_TICKS: dwell_ff      <= csr_write_data[DWELL_WIDTH-1:0];
               REG_DEFAULT_SF:  default_sf_ff <= csr_write_data[SF_WIDTH-1:0];
               default:         dwell_ff      <= dwell_ff;
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         action_ff        <= req_ch.action;
         packet_ff.sf     <= req_ch.packet_sf;
         packet_ff.rssi   <= req_ch.packet_rssi;
         packet_ff.snr    <= req_ch.packet_snr;
      end
      if (fire) begin
         tune_valid_ff <= tune_valid_in;
         tune_sf_ff    <= tune_sf_in;
         busy_ff       <= busy_in;
         done_ff       <= done_in;
         best_ff       <= best_in;
         mask_ff       <= mask_in;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.tune_valid    = tune_valid_ff;
   assign rsp_ch.tune_sf       = tune_sf_ff;
   assign rsp_ch.scan_busy     = busy_ff;
   assign rsp_ch.scan_done     = done_ff;
   assign rsp_ch.best_sf       = best_ff;
   assign rsp_ch.activity_mask = mask_ff;
endmodule
